FILE: sv/ljpf_pkg.sv
// Shared constants, codes and types of the Lennard-Jones pair force accumulator.
// No dependencies; the multiplier and top level use it by scoped names.
package ljpf_pkg;

  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int HIST_BINS_DEF     = 256;

  localparam int CFG_AW = 5;
  localparam int MUL_W  = 64;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PAIR  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_BOX_X     = 3'd0;
  localparam logic [2:0] REG_BOX_Y     = 3'd1;
  localparam logic [2:0] REG_BOX_Z     = 3'd2;
  localparam logic [2:0] REG_CUTOFF_SQ = 3'd3;
  localparam logic [2:0] REG_FOUR_EPS  = 3'd4;
  localparam logic [2:0] REG_SIGMA6    = 3'd5;
  localparam logic [2:0] REG_SHIFT     = 3'd6;
  localparam logic [2:0] REG_INV_BIN   = 3'd7;

  localparam logic [30:0] BOX_RST      = 31'd655360;
  localparam logic [31:0] CUTOFF_RST   = 32'd403046;
  localparam logic [31:0] FOUR_EPS_RST = 32'd262144;
  localparam logic [31:0] SIGMA6_RST   = 32'd65536;
  localparam logic [31:0] SHIFT_RST    = 32'd0;
  localparam logic [31:0] INV_BIN_RST  = 32'd655360;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

FILE: sv/lj_pair_force_accumulator_top.sv
// Lennard-Jones pair force accumulator, top level. Uses ljpf_pkg, ljpf_ram, ljpf_mul.
// Pair: 18 products on the shared multiplier, and a 65-step restoring divide overlapped
//   with the 32-step square root. One request at a time.
// Reset: synchronous active-low; afterwards a clearing pass over max(MAX_PARTICLES,
//   HIST_BINS) addresses zeroes the stores while in_stall is held (config writes still taken).
module lj_pair_force_accumulator_top #(
  parameter int MAX_PARTICLES = ljpf_pkg::MAX_PARTICLES_DEF,
  parameter int HIST_BINS     = ljpf_pkg::HIST_BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [9:0]                    in_first_index,
  input  logic [9:0]                    in_second_index,
  input  logic [7:0]                    in_bin_select,
  input  logic signed [31:0]            in_first_x,
  input  logic signed [31:0]            in_first_y,
  input  logic signed [31:0]            in_first_z,
  input  logic signed [31:0]            in_second_x,
  input  logic signed [31:0]            in_second_y,
  input  logic signed [31:0]            in_second_z,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_in_cutoff,
  output logic signed [63:0]            out_force_x,
  output logic signed [63:0]            out_force_y,
  output logic signed [63:0]            out_force_z,
  output logic signed [63:0]            out_energy,
  output logic signed [63:0]            out_virial_x,
  output logic signed [63:0]            out_virial_y,
  output logic signed [63:0]            out_virial_z,
  output logic [31:0]                   out_bin_count,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ljpf_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int FAW       = $clog2(MAX_PARTICLES);
  localparam int HAW       = $clog2(HIST_BINS);
  localparam int CLR_DEPTH = (MAX_PARTICLES > HIST_BINS) ? MAX_PARTICLES : HIST_BINS;
  localparam int CLRW      = $clog2(CLR_DEPTH);

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] Q_ONE   = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] Q_SIX   = 64'sh0000_0006_0000_0000;
  localparam logic signed [63:0] Q_12    = 64'sh0000_000C_0000_0000;
  localparam logic [6:0]         DIV_LAST  = 7'd64;
  localparam logic [6:0]         SQRT_STEPS = 7'd32;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_MUL, S_MULW, S_WB, S_TEST, S_DIV,
    S_FRD_I, S_FWR_I, S_FRD_J, S_FWR_J, S_RD, S_RDW, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    MO_SQX, MO_SQY, MO_SQZ, MO_I2, MO_I6, MO_RATIO, MO_COEF, MO_ENE, MO_M12,
    MO_DF, MO_DF2, MO_FX, MO_FY, MO_FZ, MO_VX, MO_VY, MO_VZ, MO_BIN
  } mop_t;

  // saturating helpers
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] usat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  // wrap one axis to the nearest periodic image
  function automatic logic signed [33:0] wrap_axis(input logic signed [31:0] p1,
                                                   input logic signed [31:0] p2,
                                                   input logic [30:0] box);
    logic signed [35:0] d, bx;
    d  = 36'(p2) - 36'(p1);
    bx = $signed({5'b0, box});
    if ((d <<< 1) > bx) d = d - bx;
    if ((d <<< 1) < -bx) d = d + bx;
    return d[33:0];
  endfunction

  // configuration registers
  logic [30:0] box_x_r, box_y_r, box_z_r;
  logic [31:0] cutoff_r, four_eps_r, sigma6_r, shift_r, inv_bin_r;
  logic        cfg_wr;

  // sequencer state
  state_t          state_r;
  mop_t            mop_r;
  ljpf_pkg::cmd_t  cmd_r;
  logic            post_r;
  logic [CLRW-1:0] clr_cnt_r;
  logic [9:0]      i_r, j_r;
  logic [7:0]      bsel_r;

  // datapath registers
  logic signed [33:0] dx_r, dy_r, dz_r;
  logic [63:0]        d2_r;
  logic signed [63:0] inv2_r, t_r, ratio_r, coef_r, ene_r, df_r;
  logic signed [63:0] fx_r, fy_r, fz_r, mres_r;
  logic signed [63:0] energy_r, vir_x_r, vir_y_r, vir_z_r;
  logic [31:0]        root_r, res_bin_r;
  logic [HAW-1:0]     bin_r;
  logic               neg_r, res_cut_r;

  // divider and square root
  logic [64:0] dv_rem_r, dv_rem_nxt, dv_sh;
  logic [63:0] dv_q_r, dv_q_nxt;
  logic [6:0]  cnt_r;
  logic [63:0] sq_n_r, sq_r_r, sq_b_r, sq_n_nxt, sq_r_nxt, sq_t;

  // output registers
  logic               out_valid_r, out_cut_r;
  logic signed [63:0] out_fx_r, out_fy_r, out_fz_r, out_en_r;
  logic signed [63:0] out_vx_r, out_vy_r, out_vz_r;
  logic [31:0]        out_bin_r;

  // multiplier port
  logic                signed [63:0] op_a, op_b;
  logic [63:0]         mag_a, mag_b;
  logic                mul_start;
  logic [127:0]        prod;
  ljpf_pkg::mul_stat_t mstat;
  logic [63:0]         mag_res, sq_val;
  logic [31:0]         bin_raw;

  // RAM ports
  logic               f_we, h_we;
  logic [FAW-1:0]     f_waddr, f_raddr;
  logic [HAW-1:0]     h_waddr, h_raddr;
  logic [63:0]        f_wx, f_wy, f_wz, f_rx, f_ry, f_rz;
  logic [31:0]        h_wdata, h_rdata;

  logic i_ok, j_ok, p_ok, b_ok, accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  assign i_ok = 32'(i_r) < 32'(MAX_PARTICLES);
  assign j_ok = 32'(j_r) < 32'(MAX_PARTICLES);
  assign p_ok = i_ok;
  assign b_ok = 32'(bsel_r) < 32'(HIST_BINS);

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      ljpf_pkg::REG_BOX_X:     prdata = {1'b0, box_x_r};
      ljpf_pkg::REG_BOX_Y:     prdata = {1'b0, box_y_r};
      ljpf_pkg::REG_BOX_Z:     prdata = {1'b0, box_z_r};
      ljpf_pkg::REG_CUTOFF_SQ: prdata = cutoff_r;
      ljpf_pkg::REG_FOUR_EPS:  prdata = four_eps_r;
      ljpf_pkg::REG_SIGMA6:    prdata = sigma6_r;
      ljpf_pkg::REG_SHIFT:     prdata = shift_r;
      ljpf_pkg::REG_INV_BIN:   prdata = inv_bin_r;
      default:                 prdata = '0;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    unique case (mop_r)
      MO_SQX:   begin op_a = 64'(dx_r);                     op_b = 64'(dx_r);    end
      MO_SQY:   begin op_a = 64'(dy_r);                     op_b = 64'(dy_r);    end
      MO_SQZ:   begin op_a = 64'(dz_r);                     op_b = 64'(dz_r);    end
      MO_I2:    begin op_a = inv2_r;                        op_b = inv2_r;       end
      MO_I6:    begin op_a = t_r;                           op_b = inv2_r;       end
      MO_RATIO: begin op_a = $signed({16'b0, sigma6_r, 16'b0});   op_b = t_r;     end
      MO_COEF:  begin op_a = $signed({16'b0, four_eps_r, 16'b0}); op_b = ratio_r; end
      MO_ENE:   begin op_a = coef_r;        op_b = sat_sub(ratio_r, Q_ONE);      end
      MO_M12:   begin op_a = Q_12;                          op_b = ratio_r;      end
      MO_DF:    begin op_a = coef_r;        op_b = sat_sub(Q_SIX, t_r);          end
      MO_DF2:   begin op_a = df_r;                          op_b = inv2_r;       end
      MO_FX:    begin op_a = df_r;          op_b = $signed({dx_r, 16'b0});       end
      MO_FY:    begin op_a = df_r;          op_b = $signed({dy_r, 16'b0});       end
      MO_FZ:    begin op_a = df_r;          op_b = $signed({dz_r, 16'b0});       end
      MO_VX:    begin op_a = $signed({dx_r, 16'b0});        op_b = fx_r;         end
      MO_VY:    begin op_a = $signed({dy_r, 16'b0});        op_b = fy_r;         end
      MO_VZ:    begin op_a = $signed({dz_r, 16'b0});        op_b = fz_r;         end
      MO_BIN:   begin op_a = $signed({32'b0, root_r});
                      op_b = $signed({32'b0, inv_bin_r});                       end
      default:  begin op_a = '0;                            op_b = '0;           end
    endcase
  end

  assign mag_a     = op_a[63] ? 64'(-op_a) : 64'(op_a);
  assign mag_b     = op_b[63] ? 64'(-op_b) : 64'(op_b);
  assign mul_start = (state_r == S_MUL);

  ljpf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mag_a),
    .b     (mag_b),
    .prod  (prod),
    .stat  (mstat)
  );

  // truncate toward zero, cap magnitude at the largest positive value
  assign mag_res = (|prod[127:95]) ? 64'(S64_MAX) : {1'b0, prod[94:32]};
  // squares are exact, saturate where the operand reached 2^32
  assign sq_val  = (|prod[127:64]) ? {64{1'b1}} : prod[63:0];
  assign bin_raw = prod[63:32];

  // one restoring divide step of 2^64 / d2 and one square root step
  always_comb begin
    dv_sh = {dv_rem_r[63:0], (cnt_r == 7'd0)};
    if (dv_sh >= {1'b0, d2_r}) begin
      dv_rem_nxt = dv_sh - {1'b0, d2_r};
      dv_q_nxt   = {dv_q_r[62:0], 1'b1};
    end else begin
      dv_rem_nxt = dv_sh;
      dv_q_nxt   = {dv_q_r[62:0], 1'b0};
    end
    sq_t = sq_r_r + sq_b_r;
    if (sq_n_r >= sq_t) begin
      sq_n_nxt = sq_n_r - sq_t;
      sq_r_nxt = (sq_r_r >> 1) + sq_b_r;
    end else begin
      sq_n_nxt = sq_n_r;
      sq_r_nxt = sq_r_r >> 1;
    end
  end

  // store ports: clearing pass, read-modify-write of both particles and the bin
  always_comb begin
    f_we    = 1'b0;
    h_we    = 1'b0;
    f_waddr = FAW'(i_r);
    f_raddr = FAW'(i_r);
    h_waddr = bin_r;
    h_raddr = bin_r;
    f_wx    = '0;
    f_wy    = '0;
    f_wz    = '0;
    h_wdata = '0;
    unique case (state_r)
      S_CLR: begin
        f_we    = 32'(clr_cnt_r) < 32'(MAX_PARTICLES);
        h_we    = 32'(clr_cnt_r) < 32'(HIST_BINS);
        f_waddr = FAW'(clr_cnt_r);
        h_waddr = HAW'(clr_cnt_r);
      end
      S_FWR_I: begin
        f_we    = i_ok;
        h_we    = 1'b1;
        f_wx    = sat_add(f_rx, fx_r);
        f_wy    = sat_add(f_ry, fy_r);
        f_wz    = sat_add(f_rz, fz_r);
        h_wdata = (h_rdata > 32'hFFFF_FFFD) ? 32'hFFFF_FFFF : h_rdata + 32'd2;
      end
      S_FRD_J: begin
        f_raddr = FAW'(j_r);
      end
      S_FWR_J: begin
        f_we    = j_ok;
        f_waddr = FAW'(j_r);
        f_wx    = sat_sub(f_rx, fx_r);
        f_wy    = sat_sub(f_ry, fy_r);
        f_wz    = sat_sub(f_rz, fz_r);
      end
      S_RD: begin
        h_raddr = HAW'(bsel_r);
      end
      default: begin
      end
    endcase
  end

  ljpf_ram #(.WIDTH(64), .DEPTH(MAX_PARTICLES)) u_fx (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wx), .raddr(f_raddr), .rdata(f_rx)
  );
  ljpf_ram #(.WIDTH(64), .DEPTH(MAX_PARTICLES)) u_fy (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wy), .raddr(f_raddr), .rdata(f_ry)
  );
  ljpf_ram #(.WIDTH(64), .DEPTH(MAX_PARTICLES)) u_fz (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wz), .raddr(f_raddr), .rdata(f_rz)
  );
  ljpf_ram #(.WIDTH(32), .DEPTH(HIST_BINS)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
  );

  // sequencer, datapath and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      post_r      <= 1'b0;
      clr_cnt_r   <= '0;
      mop_r       <= MO_SQX;
      cmd_r       <= ljpf_pkg::CMD_NOP;
      out_valid_r <= 1'b0;
      box_x_r     <= ljpf_pkg::BOX_RST;
      box_y_r     <= ljpf_pkg::BOX_RST;
      box_z_r     <= ljpf_pkg::BOX_RST;
      cutoff_r    <= ljpf_pkg::CUTOFF_RST;
      four_eps_r  <= ljpf_pkg::FOUR_EPS_RST;
      sigma6_r    <= ljpf_pkg::SIGMA6_RST;
      shift_r     <= ljpf_pkg::SHIFT_RST;
      inv_bin_r   <= ljpf_pkg::INV_BIN_RST;
    end else begin
      // configuration writes
      if (cfg_wr) begin
        unique case (paddr[4:2])
          ljpf_pkg::REG_BOX_X:     box_x_r    <= pwdata[30:0];
          ljpf_pkg::REG_BOX_Y:     box_y_r    <= pwdata[30:0];
          ljpf_pkg::REG_BOX_Z:     box_z_r    <= pwdata[30:0];
          ljpf_pkg::REG_CUTOFF_SQ: cutoff_r   <= pwdata;
          ljpf_pkg::REG_FOUR_EPS:  four_eps_r <= pwdata;
          ljpf_pkg::REG_SIGMA6:    sigma6_r   <= pwdata;
          ljpf_pkg::REG_SHIFT:     shift_r    <= pwdata;
          ljpf_pkg::REG_INV_BIN:   inv_bin_r  <= pwdata;
          default: begin
          end
        endcase
      end

      // drop the result once taken
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= ljpf_pkg::cmd_t'(in_cmd);
            i_r       <= in_first_index;
            j_r       <= in_second_index;
            bsel_r    <= in_bin_select;
            res_cut_r <= 1'b0;
            dx_r      <= wrap_axis(in_first_x, in_second_x, box_x_r);
            dy_r      <= wrap_axis(in_first_y, in_second_y, box_y_r);
            dz_r      <= wrap_axis(in_first_z, in_second_z, box_z_r);
            d2_r      <= '0;
            unique case (ljpf_pkg::cmd_t'(in_cmd))
              ljpf_pkg::CMD_CLEAR: begin
                post_r    <= 1'b1;
                clr_cnt_r <= '0;
                state_r   <= S_CLR;
              end
              ljpf_pkg::CMD_PAIR: begin
                mop_r   <= MO_SQX;
                state_r <= S_MUL;
              end
              ljpf_pkg::CMD_READ: state_r <= S_RD;
              default:            state_r <= S_OUT;
            endcase
          end
        end

        S_CLR: begin
          energy_r <= '0;
          vir_x_r  <= '0;
          vir_y_r  <= '0;
          vir_z_r  <= '0;
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CLRW'(CLR_DEPTH - 1)) begin
            state_r <= post_r ? S_OUT : S_IDLE;
          end
        end

        S_MUL: begin
          neg_r   <= op_a[63] ^ op_b[63];
          state_r <= S_MULW;
        end

        S_MULW: begin
          if (mstat.done) begin
            mres_r  <= neg_r ? -$signed(mag_res) : $signed(mag_res);
            state_r <= S_WB;
          end
        end

        S_WB: begin
          state_r <= S_MUL;
          unique case (mop_r)
            MO_SQX:   begin d2_r <= usat_add(d2_r, sq_val); mop_r <= MO_SQY; end
            MO_SQY:   begin d2_r <= usat_add(d2_r, sq_val); mop_r <= MO_SQZ; end
            MO_SQZ:   begin
              d2_r    <= usat_add(d2_r, sq_val);
              mop_r   <= MO_I2;
              state_r <= S_TEST;
            end
            MO_I2:    begin t_r <= mres_r;     mop_r <= MO_I6;    end
            MO_I6:    begin t_r <= mres_r;     mop_r <= MO_RATIO; end
            MO_RATIO: begin ratio_r <= mres_r; mop_r <= MO_COEF;  end
            MO_COEF:  begin coef_r <= mres_r;  mop_r <= MO_ENE;   end
            MO_ENE:   begin
              ene_r <= sat_sub(mres_r, $signed({{16{shift_r[31]}}, shift_r, 16'b0}));
              mop_r <= MO_M12;
            end
            MO_M12:   begin
              t_r      <= mres_r;
              energy_r <= sat_add(energy_r, ene_r);
              mop_r    <= MO_DF;
            end
            MO_DF:    begin df_r <= mres_r; mop_r <= MO_DF2; end
            MO_DF2:   begin df_r <= mres_r; mop_r <= MO_FX;  end
            MO_FX:    begin fx_r <= mres_r; mop_r <= MO_FY;  end
            MO_FY:    begin fy_r <= mres_r; mop_r <= MO_FZ;  end
            MO_FZ:    begin fz_r <= mres_r; mop_r <= MO_VX;  end
            MO_VX:    begin vir_x_r <= sat_sub(vir_x_r, mres_r); mop_r <= MO_VY; end
            MO_VY:    begin vir_y_r <= sat_sub(vir_y_r, mres_r); mop_r <= MO_VZ; end
            MO_VZ:    begin vir_z_r <= sat_sub(vir_z_r, mres_r); mop_r <= MO_BIN; end
            MO_BIN:   begin
              // saturate the bin at the last one
              bin_r   <= (bin_raw > 32'(HIST_BINS - 1)) ? HAW'(HIST_BINS - 1)
                                                         : HAW'(bin_raw);
              state_r <= S_FRD_I;
            end
            default:  state_r <= S_IDLE;
          endcase
        end

        S_TEST: begin
          // zero distance counts as outside the cutoff
          if ((d2_r == '0) || (d2_r >= {16'b0, cutoff_r, 16'b0})) begin
            state_r <= S_OUT;
          end else begin
            dv_rem_r <= '0;
            dv_q_r   <= '0;
            cnt_r    <= '0;
            sq_n_r   <= d2_r;
            sq_r_r   <= '0;
            sq_b_r   <= 64'h4000_0000_0000_0000;
            state_r  <= S_DIV;
          end
        end

        S_DIV: begin
          dv_rem_r <= dv_rem_nxt;
          dv_q_r   <= dv_q_nxt;
          cnt_r    <= cnt_r + 7'd1;
          if (cnt_r < SQRT_STEPS) begin
            sq_n_r <= sq_n_nxt;
            sq_r_r <= sq_r_nxt;
            sq_b_r <= sq_b_r >> 2;
          end
          if (cnt_r == DIV_LAST) begin
            root_r <= sq_r_r[31:0];
            if ((d2_r <= 64'd2) || (dv_q_nxt > 64'(S64_MAX))) begin
              inv2_r <= S64_MAX;
            end else begin
              inv2_r <= $signed(dv_q_nxt);
            end
            state_r <= S_MUL;
          end
        end

        S_FRD_I: state_r <= S_FWR_I;
        S_FWR_I: state_r <= S_FRD_J;
        S_FRD_J: state_r <= S_FWR_J;
        S_FWR_J: begin
          res_cut_r <= 1'b1;
          state_r   <= S_OUT;
        end

        S_RD: state_r <= S_RDW;
        S_RDW: begin
          fx_r      <= p_ok ? $signed(f_rx) : '0;
          fy_r      <= p_ok ? $signed(f_ry) : '0;
          fz_r      <= p_ok ? $signed(f_rz) : '0;
          res_bin_r <= b_ok ? h_rdata : '0;
          state_r   <= S_OUT;
        end

        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_cut_r   <= res_cut_r;
            if (cmd_r == ljpf_pkg::CMD_READ) begin
              out_fx_r  <= fx_r;
              out_fy_r  <= fy_r;
              out_fz_r  <= fz_r;
              out_en_r  <= energy_r;
              out_vx_r  <= vir_x_r;
              out_vy_r  <= vir_y_r;
              out_vz_r  <= vir_z_r;
              out_bin_r <= res_bin_r;
            end else begin
              out_fx_r  <= '0;
              out_fy_r  <= '0;
              out_fz_r  <= '0;
              out_en_r  <= '0;
              out_vx_r  <= '0;
              out_vy_r  <= '0;
              out_vz_r  <= '0;
              out_bin_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_in_cutoff = out_cut_r;
  assign out_force_x   = out_fx_r;
  assign out_force_y   = out_fy_r;
  assign out_force_z   = out_fz_r;
  assign out_energy    = out_en_r;
  assign out_virial_x  = out_vx_r;
  assign out_virial_y  = out_vy_r;
  assign out_virial_z  = out_vz_r;
  assign out_bin_count = out_bin_r;

  // the shared multiplier is never restarted while it works
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mstat.busy)
    else $error("multiplier started while busy");

  // a product completes only while the sequencer waits for it
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mstat.done |-> (state_r == S_MULW))
    else $error("product finished outside the wait state");

  // an accepted request locks the input for at least the next cycle
  a_lock: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not held after accepting a request");

  // no store write while the block is idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!f_we && !h_we))
    else $error("store written while idle");

  // the divide never runs past its last step
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= DIV_LAST))
    else $error("divider step count out of range");

endmodule

FILE: sv/ljpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ljpf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ljpf_mul.sv
// Iterative 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// Depends on ljpf_pkg for the operand width and the status struct.
module ljpf_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ljpf_pkg::MUL_W-1:0]    a,
  input  logic [ljpf_pkg::MUL_W-1:0]    b,
  output logic [2*ljpf_pkg::MUL_W-1:0]  prod,
  output ljpf_pkg::mul_stat_t           stat
);

  localparam int HW = ljpf_pkg::MUL_W / 2;

  logic [ljpf_pkg::MUL_W-1:0]   a_r, b_r;
  logic [2*ljpf_pkg::MUL_W-1:0] acc_r;
  logic [1:0]                   step_r;
  logic                         busy_r, done_r;
  logic [HW-1:0]                a_h, b_h;
  logic [ljpf_pkg::MUL_W-1:0]   pp;
  logic [2*ljpf_pkg::MUL_W-1:0] pp_ext;

  // step 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi
  assign a_h = step_r[1] ? a_r[ljpf_pkg::MUL_W-1:HW] : a_r[HW-1:0];
  assign b_h = step_r[0] ? b_r[ljpf_pkg::MUL_W-1:HW] : b_r[HW-1:0];
  assign pp  = a_h * b_h;

  always_comb begin
    unique case (step_r)
      2'd0:    pp_ext = {{ljpf_pkg::MUL_W{1'b0}}, pp};
      2'd3:    pp_ext = {pp, {ljpf_pkg::MUL_W{1'b0}}};
      default: pp_ext = {{HW{1'b0}}, pp, {HW{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        step_r <= 2'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r  <= acc_r + pp_ext;
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
